// ----- rtl/dbof_pkg.sv -----
package dbof_pkg;

  localparam int FIFO_DEPTH   = 64;
  localparam int BUDGET_LIMIT = 16;

  localparam int HANDLE_W = 32;
  localparam int BUDGET_W = 5;
  localparam int LIMIT_W  = 7;
  localparam int CFG_W    = LIMIT_W;
  localparam int CODE_W   = 3;
  localparam int PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [1:0] CFG_SEND_BUDGET      = 2'd0;
  localparam logic [1:0] CFG_FIFO_LIMIT       = 2'd1;
  localparam logic [1:0] CFG_OVERWRITE_OLDEST = 2'd2;

  typedef enum logic [1:0] {
    ACT_ARRIVE    = 2'd0,
    ACT_EOC       = 2'd1,
    ACT_LINK_UP   = 2'd2,
    ACT_LINK_DOWN = 2'd3
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_OK          = 3'd0,
    CODE_STORED      = 3'd1,
    CODE_REFUSED     = 3'd2,
    CODE_NOT_FOUND   = 3'd3,
    CODE_SEND_FAILED = 3'd4
  } code_t;

  // which result the datapath builds
  typedef enum logic [2:0] {
    RES_DIRECT,
    RES_DROP,
    RES_STORED,
    RES_REFUSED,
    RES_DRAIN
  } res_t;

  typedef struct packed {
    logic latch;
    logic emit;
    res_t res_sel;
    logic last;
    logic push;
    logic pop;
    logic sent_inc;
    logic sent_clr;
    logic link_set;
    logic link_clr;
  } dbof_cmd_t;

  typedef struct packed {
    action_t action;
    logic    direct;
    logic    found;
    logic    accepted;
    logic    full;
    logic    can_drop;
    logic    drain_ok;
    logic    drain_more;
  } dbof_sts_t;

endpackage

// ----- rtl/dbof_ctrl.sv -----
module dbof_ctrl
  import dbof_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dbof_sts_t sts,
  output dbof_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DROP_RD,
    S_DROP_OUT,
    S_PUSH,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    cmd.res_sel = RES_DIRECT;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        unique case (sts.action)
          ACT_ARRIVE: begin
            if (sts.direct) begin
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
              cmd.res_sel  = RES_DIRECT;
              cmd.sent_inc = sts.found & sts.accepted;
            end else if (sts.can_drop) begin
              state_nxt = S_DROP_RD;
            end else if (sts.full) begin
              cmd.emit    = 1'b1;
              cmd.last    = 1'b1;
              cmd.res_sel = RES_REFUSED;
            end else begin
              cmd.emit    = 1'b1;
              cmd.last    = 1'b1;
              cmd.res_sel = RES_STORED;
              cmd.push    = 1'b1;
            end
          end
          ACT_EOC: begin
            if (sts.drain_ok) begin
              state_nxt = S_DRAIN_RD;
            end else begin
              cmd.sent_clr = 1'b1;
            end
          end
          ACT_LINK_UP:   cmd.link_set = 1'b1;
          ACT_LINK_DOWN: cmd.link_clr = 1'b1;
          default: ;
        endcase
      end
      // wait for the registered read of the oldest slot
      S_DROP_RD: state_nxt = S_DROP_OUT;
      S_DROP_OUT: begin
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_DROP;
        cmd.pop     = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_PUSH: begin
        cmd.emit    = 1'b1;
        cmd.last    = 1'b1;
        cmd.res_sel = RES_STORED;
        cmd.push    = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DRAIN_RD: state_nxt = S_DRAIN_OUT;
      S_DRAIN_OUT: begin
        cmd.emit     = 1'b1;
        cmd.res_sel  = RES_DRAIN;
        cmd.pop      = 1'b1;
        cmd.sent_inc = 1'b1;
        if (sts.drain_more) begin
          state_nxt = S_DRAIN_RD;
        end else begin
          cmd.last     = 1'b1;
          cmd.sent_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ----- rtl/dbof_dp.sv -----
module dbof_dp
  import dbof_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dbof_cmd_t           cmd,
  output dbof_sts_t           sts,
  input  logic [1:0]          in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic                in_entry_found,
  input  logic                in_send_accepted,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                out_valid,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                out_transmit,
  output logic                out_release_res,
  output logic [CODE_W-1:0]   out_code,
  output logic                out_last
);

  logic [BUDGET_W-1:0] budget_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic                ovw_r;

  action_t             act_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic                found_r;
  logic                acc_r;

  logic [HANDLE_W-1:0] mem [FIFO_DEPTH];
  logic [HANDLE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]    rd_ptr_r, wr_ptr_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic                link_r;
  logic [BUDGET_W-1:0] sent_r;

  logic                valid_r;
  logic [HANDLE_W-1:0] ohdl_r;
  logic                otx_r, orel_r, olast_r;
  code_t               ocode_r;

  logic [HANDLE_W-1:0] res_hdl;
  logic                res_tx, res_rel;
  code_t               res_code;

  logic                budget_left, full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign budget_left = (sent_r < budget_r);
  assign full = (CMP_W'(fill_r) >= CMP_W'(limit_r)) || (fill_r >= CNT_W'(FIFO_DEPTH));

  assign sts.action     = act_r;
  assign sts.direct     = link_r & budget_left;
  assign sts.found      = found_r;
  assign sts.accepted   = acc_r;
  assign sts.full       = full;
  assign sts.can_drop   = full & ovw_r & (fill_r != '0);
  assign sts.drain_ok   = link_r & (fill_r != '0) & budget_left;
  assign sts.drain_more = link_r & (fill_r > CNT_W'(1)) &
                          (({1'b0, sent_r} + 1'b1) < {1'b0, budget_r});

  // configuration; a limit above FIFO_DEPTH or a budget field above BUDGET_LIMIT keeps the old setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_W'(5);
      limit_r  <= LIMIT_W'(FIFO_DEPTH);
      ovw_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEND_BUDGET: begin
          if ({2'b00, cfg_data[BUDGET_W-1:0]} <= 7'(BUDGET_LIMIT)) begin
            budget_r <= cfg_data[BUDGET_W-1:0];
          end
        end
        CFG_FIFO_LIMIT: begin
          if (CMP_W'(cfg_data) <= CMP_W'(FIFO_DEPTH)) begin
            limit_r <= cfg_data;
          end
        end
        CFG_OVERWRITE_OLDEST: ovw_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= action_t'(in_action);
      hdl_r   <= in_handle;
      found_r <= in_entry_found;
      acc_r   <= in_send_accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= hdl_r;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_comb begin
    case ({cmd.push, cmd.pop})
      2'b10:   fill_nxt = fill_r + CNT_W'(1);
      2'b01:   fill_nxt = fill_r - CNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      link_r   <= 1'b0;
      sent_r   <= '0;
    end else begin
      if (cmd.push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (cmd.pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      fill_r <= fill_nxt;
      if (cmd.link_set) link_r <= 1'b1;
      else if (cmd.link_clr) link_r <= 1'b0;
      // clear wins over the final drain's count
      if (cmd.sent_clr) sent_r <= '0;
      else if (cmd.sent_inc) sent_r <= sent_r + BUDGET_W'(1);
    end
  end

  always_comb begin
    res_hdl  = hdl_r;
    res_tx   = 1'b0;
    res_rel  = 1'b0;
    res_code = CODE_OK;
    case (cmd.res_sel)
      RES_DIRECT: begin
        if (!found_r) begin
          res_code = CODE_NOT_FOUND;
        end else if (acc_r) begin
          res_tx   = 1'b1;
          res_rel  = 1'b1;
          res_code = CODE_OK;
        end else begin
          res_code = CODE_SEND_FAILED;
        end
      end
      RES_DROP: begin
        res_hdl  = rd_data_r;
        res_rel  = 1'b1;
        res_code = CODE_OK;
      end
      RES_STORED:  res_code = CODE_STORED;
      RES_REFUSED: res_code = CODE_REFUSED;
      RES_DRAIN: begin
        res_hdl  = rd_data_r;
        res_tx   = 1'b1;
        res_rel  = 1'b1;
        res_code = CODE_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ohdl_r  <= res_hdl;
      otx_r   <= res_tx;
      orel_r  <= res_rel;
      ocode_r <= res_code;
      olast_r <= cmd.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_handle      = ohdl_r;
  assign out_transmit    = otx_r;
  assign out_release_res = orel_r;
  assign out_code        = ocode_r;
  assign out_last        = olast_r;

endmodule

// ----- rtl/downlink_budget_overflow_fifo.sv -----
// Downlink scheduler with a per-cycle send budget and a bounded overflow FIFO.
// Input: pulse start with in_action, in_handle, in_entry_found and
// in_send_accepted; the word is taken when start is high and busy is low.
// Results: each word shows on out_* for one cycle with out_valid high and
// out_last on the final word of an input; the receiver cannot stall, so
// results must be taken as they come.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// follows !busy. Writes are meant for idle periods only.
// Timing: an arrival's result shows in the first cycle with busy low; an
// arrival that drops the oldest handle first gives the dropped handle, then
// the stored result. Link events give no result. End of cycle drains each
// handle via a read and an output state, set by the registered FIFO read port.
// Reset clears pointers, fill count, link state and the budget counter;
// FIFO contents are never cleared, the fill count guards every read.
module downlink_budget_overflow_fifo
  import dbof_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_action,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic                in_entry_found,
  input  logic                in_send_accepted,
  output logic                out_valid,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                out_transmit,
  output logic                out_release_res,
  output logic [CODE_W-1:0]   out_code,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  dbof_cmd_t cmd;
  dbof_sts_t sts;

  assign cfg_ready = ~busy;

  dbof_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dbof_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_handle        (in_handle),
    .in_entry_found   (in_entry_found),
    .in_send_accepted (in_send_accepted),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_handle       (out_handle),
    .out_transmit     (out_transmit),
    .out_release_res  (out_release_res),
    .out_code         (out_code),
    .out_last         (out_last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  a_result_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe outside of work on an item");

  a_drop_then_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.res_sel == RES_DROP |=> cmd.emit && cmd.push && cmd.last)
    else $error("dropped oldest handle not followed by store");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !cmd.pop)
    else $error("push and pop in the same cycle");

endmodule
